>>> src/affine_3x4_transform_engine_top_assert.svh
// assertion macros for the affine transform engine
`ifndef AFFINE_3X4_TRANSFORM_ENGINE_TOP_ASSERT_SVH
`define AFFINE_3X4_TRANSFORM_ENGINE_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define AFF_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aff assertion failed");

// consequent checked in the next cycle
`define AFF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aff assertion failed");

`endif

>>> src/aff_pkg.sv
`default_nettype none

package aff_pkg;

    localparam int ACC_W = 66;

    typedef logic signed [31:0]      t_word;
    typedef logic signed [17:0]      t_trig;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [2:0]              t_req_code;
    typedef logic [1:0]              t_axis;

    localparam t_req_code REQ_IDENTITY = 3'd0;
    localparam t_req_code REQ_UNIFORM  = 3'd1;
    localparam t_req_code REQ_ROW      = 3'd2;
    localparam t_req_code REQ_SHIFT    = 3'd3;
    localparam t_req_code REQ_ROTATE   = 3'd4;
    localparam t_req_code REQ_VERTEX   = 3'd5;

    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    localparam t_acc WORD_MAX = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
    localparam t_acc WORD_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

    typedef struct packed {
        t_req_code req_type;
        t_word     arg_x;
        t_word     arg_y;
        t_word     arg_z;
        t_axis     rot_axis;
        t_trig     cos_val;
        t_trig     sin_val;
        logic      last_in_batch;
    } t_req_item;

    typedef struct packed {
        t_word out_x;
        t_word out_y;
        t_word out_z;
        logic  saturated;
        logic  last_vertex;
    } t_res_item;

    typedef struct packed {
        t_word value;
        logic  clip;
    } t_sat;

    function automatic t_sat sat_word(input t_acc v);
        t_sat r;
        r.clip = 1'b1;
        if (v > WORD_MAX) begin
            r.value = 32'sh7fff_ffff;
        end else if (v < WORD_MIN) begin
            r.value = 32'sh8000_0000;
        end else begin
            r.value = v[31:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/aff_ifs.sv
`default_nettype none

interface aff_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_z;
    logic [1:0]  rot_axis;
    logic signed [17:0] cos_val;
    logic signed [17:0] sin_val;
    logic        last_in_batch;

    modport source (
        output valid, req_type, arg_x, arg_y, arg_z, rot_axis, cos_val, sin_val,
               last_in_batch,
        input  ready
    );
    modport sink (
        input  valid, req_type, arg_x, arg_y, arg_z, rot_axis, cos_val, sin_val,
               last_in_batch,
        output ready
    );
endinterface

interface aff_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        saturated;
    logic        last_vertex;

    modport source (
        output valid, out_x, out_y, out_z, saturated, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, saturated, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

>>> src/aff_lane.sv
`default_nettype none

// one matrix entry: entry * op_a +/- partner * op_s, rounded half up
module aff_lane #(
    parameter int FRAC_BITS = 16
) (
    input  aff_pkg::t_word i_entry,
    input  aff_pkg::t_word i_op_a,
    input  aff_pkg::t_word i_partner,
    input  aff_pkg::t_trig i_op_s,
    input  logic           i_sub,
    output aff_pkg::t_acc  o_round
);
    import aff_pkg::*;

    localparam t_acc Bias = t_acc'(1) <<< (FRAC_BITS - 1);

    logic signed [63:0] w_prod_a;
    logic signed [49:0] w_prod_s;
    t_acc               w_cross;
    t_acc               w_sum;

    assign w_prod_a = 64'(i_entry) * 64'(i_op_a);
    assign w_prod_s = 50'(i_partner) * 50'(i_op_s);
    assign w_cross  = i_sub ? -t_acc'(w_prod_s) : t_acc'(w_prod_s);
    assign w_sum    = t_acc'(w_prod_a) + w_cross;
    assign o_round  = (w_sum + Bias) >>> FRAC_BITS;

endmodule

`default_nettype wire

>>> src/aff_core.sv
`default_nettype none

// matrix store, twelve entry lanes, update and vertex sums
module aff_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  aff_pkg::t_req_item i_item,
    output aff_pkg::t_res_item o_res
);
    import aff_pkg::*;

    localparam t_word One = 32'sd1 <<< FRAC_BITS;

    t_word r_m [12];
    t_word n_m [12];
    logic  r_clipped;
    logic  n_clipped;

    t_word      w_arg [3];
    logic [2:0] w_is_a;
    logic [2:0] w_is_b;
    logic [1:0] w_partner [3];
    t_acc       w_round [12];
    logic [11:0] w_clip;
    t_sat       w_vsat [3];

    assign w_arg[0] = i_item.arg_x;
    assign w_arg[1] = i_item.arg_y;
    assign w_arg[2] = i_item.arg_z;

    // row roles for a rotation: a gets +sin partner, b gets -sin partner
    always_comb begin
        w_is_a       = 3'b000;
        w_is_b       = 3'b000;
        w_partner[0] = 2'd0;
        w_partner[1] = 2'd0;
        w_partner[2] = 2'd0;
        unique case (i_item.rot_axis)
            AXIS_X: begin
                w_is_a[1] = 1'b1; w_partner[1] = 2'd2;
                w_is_b[2] = 1'b1; w_partner[2] = 2'd1;
            end
            AXIS_Y: begin
                w_is_a[0] = 1'b1; w_partner[0] = 2'd2;
                w_is_b[2] = 1'b1; w_partner[2] = 2'd0;
            end
            AXIS_Z: begin
                w_is_a[1] = 1'b1; w_partner[1] = 2'd0;
                w_is_b[0] = 1'b1; w_partner[0] = 2'd1;
            end
            default: begin
            end
        endcase
    end

    for (genvar row = 0; row < 3; row++) begin : g_row
        for (genvar col = 0; col < 4; col++) begin : g_col
            localparam int K = row * 4 + col;

            t_word w_op_a;
            t_trig w_op_s;
            t_word w_partner_val;
            logic  w_role;
            t_sat  w_upd;
            t_sat  w_shift;

            assign w_role = w_is_a[row] | w_is_b[row];

            always_comb begin
                unique case (w_partner[row])
                    2'd0:    w_partner_val = r_m[col];
                    2'd1:    w_partner_val = r_m[4 + col];
                    default: w_partner_val = r_m[8 + col];
                endcase
            end

            always_comb begin
                w_op_a = '0;
                w_op_s = '0;
                unique case (i_item.req_type)
                    REQ_UNIFORM: w_op_a = i_item.arg_x;
                    REQ_ROW:     w_op_a = w_arg[row];
                    REQ_ROTATE: begin
                        w_op_a = 32'(i_item.cos_val);
                        w_op_s = w_role ? i_item.sin_val : '0;
                    end
                    REQ_VERTEX:  w_op_a = (col < 3) ? w_arg[col % 3] : '0;
                    default: begin
                    end
                endcase
            end

            aff_lane #(
                .FRAC_BITS(FRAC_BITS)
            ) u_lane (
                .i_entry  (r_m[K]),
                .i_op_a   (w_op_a),
                .i_partner(w_partner_val),
                .i_op_s   (w_op_s),
                .i_sub    (w_is_b[row]),
                .o_round  (w_round[K])
            );

            assign w_upd   = sat_word(w_round[K]);
            assign w_shift = sat_word(t_acc'(r_m[K]) + t_acc'(w_arg[row]));

            always_comb begin
                n_m[K]    = r_m[K];
                w_clip[K] = 1'b0;
                unique case (i_item.req_type)
                    REQ_IDENTITY: n_m[K] = (row == col) ? One : '0;
                    REQ_UNIFORM, REQ_ROW: begin
                        n_m[K]    = w_upd.value;
                        w_clip[K] = w_upd.clip;
                    end
                    REQ_SHIFT: begin
                        if (col == 3) begin
                            n_m[K]    = w_shift.value;
                            w_clip[K] = w_shift.clip;
                        end
                    end
                    REQ_ROTATE: begin
                        if (w_role) begin
                            n_m[K]    = w_upd.value;
                            w_clip[K] = w_upd.clip;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_m[K] <= (row == col) ? One : '0;
                end else if (i_adv) begin
                    r_m[K] <= n_m[K];
                end
            end
        end

        // each product rounded alone, then summed exactly with the translation
        assign w_vsat[row] = sat_word(t_acc'(r_m[row * 4 + 3]) + w_round[row * 4]
                                      + w_round[row * 4 + 1] + w_round[row * 4 + 2]);
    end

    assign n_clipped = (i_item.req_type == REQ_IDENTITY) ? 1'b0 : (r_clipped | (|w_clip));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clipped <= 1'b0;
        end else if (i_adv) begin
            r_clipped <= n_clipped;
        end
    end

    assign o_res.out_x       = w_vsat[0].value;
    assign o_res.out_y       = w_vsat[1].value;
    assign o_res.out_z       = w_vsat[2].value;
    assign o_res.saturated   = w_vsat[0].clip | w_vsat[1].clip | w_vsat[2].clip | r_clipped;
    assign o_res.last_vertex = i_item.last_in_batch;

endmodule

`default_nettype wire

>>> src/affine_3x4_transform_engine_top.sv
`default_nettype none
`include "affine_3x4_transform_engine_top_assert.svh"

// Affine 3x4 transform engine: holds a 3x4 matrix in signed fixed point with
// FRAC_BITS fraction bits (identity after reset) and takes one request per
// transfer on i_req: identity, uniform scale, per-row scale, translate,
// rotate about x, y or z from a given cosine and sine, or transform a vertex.
// Only a vertex request yields a transfer on o_res, after it passes the input
// register and then the result register. One request is taken every cycle
// while o_res keeps up; in the input register, twelve parallel entry lanes
// either update the matrix or form the vertex, so a matrix update is seen by
// the very next request. saturated reports clipping of this vertex or of any
// matrix update since the last identity request.
module affine_3x4_transform_engine_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aff_req_if.sink          i_req,
    aff_res_if.source        o_res
);
    import aff_pkg::*;

    logic      r_in_valid;
    t_req_item r_in;
    logic      r_out_valid;
    t_res_item r_out;
    logic      w_adv;
    logic      w_is_vertex;
    t_res_item w_res;

    assign w_is_vertex = (r_in.req_type == REQ_VERTEX);
    // a vertex waits only when the result register is full and stalled
    assign w_adv       = r_in_valid && (!w_is_vertex || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.req_type      <= i_req.req_type;
            r_in.arg_x         <= i_req.arg_x;
            r_in.arg_y         <= i_req.arg_y;
            r_in.arg_z         <= i_req.arg_z;
            r_in.rot_axis      <= i_req.rot_axis;
            r_in.cos_val       <= i_req.cos_val;
            r_in.sin_val       <= i_req.sin_val;
            r_in.last_in_batch <= i_req.last_in_batch;
        end
    end

    aff_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_item (r_in),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_vertex) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_vertex) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_x       = r_out.out_x;
    assign o_res.out_y       = r_out.out_y;
    assign o_res.out_z       = r_out.out_z;
    assign o_res.saturated   = r_out.saturated;
    assign o_res.last_vertex = r_out.last_vertex;

    `AFF_ASSERT_NEXT(a_vertex_lands, i_clk, i_rst_n, w_adv && w_is_vertex, r_out_valid)
    `AFF_ASSERT_NEXT(a_in_holds, i_clk, i_rst_n, r_in_valid && !w_adv,
                     r_in_valid && $stable(r_in))
    `AFF_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_req.ready,
                    r_in_valid && w_is_vertex && r_out_valid && !o_res.ready)

endmodule

`default_nettype wire
